FILE: design/ceat_pkg.sv
// ----------------------------------------------------------------------------
// ceat_pkg
// Shared types and constants of the communication edge anomaly table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ceat_pkg;

  localparam logic [1:0]  FUNC_PRELOAD = 2'd0;
  localparam logic [63:0] MIX_K        = 64'h9E3779B97F4A7C15;
  localparam int unsigned MIX_SHIFT    = 29;

  typedef enum logic [1:0] {
    V_KNOWN      = 2'd0,
    V_NEW_EDGE   = 2'd1,
    V_NEW_SOURCE = 2'd2,
    V_FULL       = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_MIX,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ
  } back_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] source_pc;
    logic [63:0] sink_pc;
  } item_t;

endpackage

`default_nettype wire

FILE: design/ceat_intf.sv
// ----------------------------------------------------------------------------
// ceat channel interfaces
// Valid/ready channels for trap items and for verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ceat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] source_pc;
  logic [63:0] sink_pc;

  modport source (output valid, func, source_pc, sink_pc, input ready);
  modport sink (input valid, func, source_pc, sink_pc, output ready);
endinterface

interface ceat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       was_write;

  modport source (output valid, verdict, was_write, input ready);
  modport sink (input valid, verdict, was_write, output ready);
endinterface

`default_nettype wire

FILE: design/comm_edge_anomaly_table_top.sv
// ----------------------------------------------------------------------------
// comm_edge_anomaly_table_top
// Communication edge anomaly table: hashing front, queue, store back end.
// ----------------------------------------------------------------------------
// path: three multiplies, three mix steps and two remainder passes in the front,
//   hand-over through the queue, then store read and write-back in the back end
// issue: the front takes a new item only once the last one is pushed into the
//   queue, so its hashing and remainder steps set the rate
// reset: synchronous active-low; the back then clears both stores, one set
//   per cycle until every set of the larger store is cleared, before taking items
`timescale 1ns / 1ps
`default_nettype none

module comm_edge_anomaly_table_top #(
  parameter int unsigned EDGE_SETS   = 256,
  parameter int unsigned EDGE_WAYS   = 4,
  parameter int unsigned SOURCE_SETS = 256,
  parameter int unsigned SOURCE_WAYS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ceat_in_if.sink    in_ch,
  ceat_out_if.source out_ch
);

  localparam int unsigned SIW = (SOURCE_SETS > 1) ? $clog2(SOURCE_SETS) : 1;
  localparam int unsigned EIW = (EDGE_SETS > 1) ? $clog2(EDGE_SETS) : 1;

  logic            push_valid, push_ready, head_valid, pop;
  ceat_pkg::item_t push_item, head_item;
  logic [SIW-1:0]  push_sset, head_sset;
  logic [EIW-1:0]  push_eset, head_eset;

  ceat_front #(.EDGE_SETS(EDGE_SETS), .SOURCE_SETS(SOURCE_SETS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .push_sset(push_sset), .push_eset(push_eset)
  );

  ceat_queue #(.SIW(SIW), .EIW(EIW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .push_sset(push_sset), .push_eset(push_eset),
    .head_valid(head_valid), .pop(pop), .head_item(head_item),
    .head_sset(head_sset), .head_eset(head_eset)
  );

  ceat_back #(
    .EDGE_SETS(EDGE_SETS), .EDGE_WAYS(EDGE_WAYS),
    .SOURCE_SETS(SOURCE_SETS), .SOURCE_WAYS(SOURCE_WAYS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .pop(pop),
    .head_item(head_item), .head_sset(head_sset), .head_eset(head_eset),
    .out_ch(out_ch)
  );

endmodule

`default_nettype wire

FILE: design/ceat_ram.sv
// ----------------------------------------------------------------------------
// ceat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ceat_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                      wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/ceat_front.sv
// ----------------------------------------------------------------------------
// ceat_front
// Takes trap items and works out their source set and edge set indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ceat_front #(
  parameter int unsigned EDGE_SETS   = 256,
  parameter int unsigned SOURCE_SETS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ceat_in_if.sink                   in_ch,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output ceat_pkg::item_t           push_item,
  output logic [((SOURCE_SETS > 1) ? $clog2(SOURCE_SETS) : 1)-1:0] push_sset,
  output logic [((EDGE_SETS > 1) ? $clog2(EDGE_SETS) : 1)-1:0]     push_eset
);

  localparam int unsigned SIW    = (SOURCE_SETS > 1) ? $clog2(SOURCE_SETS) : 1;
  localparam int unsigned EIW    = (EDGE_SETS > 1) ? $clog2(EDGE_SETS) : 1;
  localparam logic [63:0] ONES32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] E_DIV  = 32'(EDGE_SETS);
  localparam logic [31:0] S_DIV  = 32'(SOURCE_SETS);
  // truncated reciprocals, the estimate is never above the true quotient
  localparam logic [31:0] E_RECIP = 32'(ONES32 / 64'(EDGE_SETS));
  localparam logic [31:0] S_RECIP = 32'(ONES32 / 64'(SOURCE_SETS));

  ceat_pkg::front_state_t state_r, state_nxt;
  ceat_pkg::item_t        item_r, item_nxt;
  logic [1:0]             job_r, job_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic [63:0]            op_r, op_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [63:0]            prod_r, prod_nxt;
  logic [63:0]            div_r, div_nxt;
  logic [15:0]            rem_r, rem_nxt;
  logic [31:0]            t_r, t_nxt;
  logic [SIW-1:0]         sset_r, sset_nxt;
  logic [EIW-1:0]         eset_r, eset_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mixv;
  logic [31:0] tnow, divisor, recip, rest, remv;

  assign tnow    = {rem_r, div_r[63:48]};
  assign divisor = (job_r == 2'd1) ? E_DIV : S_DIV;
  assign recip   = (job_r == 2'd1) ? E_RECIP : S_RECIP;

  always_comb begin
    if (state_r == ceat_pkg::F_MOD) begin
      if (cnt_r[1:0] == 2'd0) begin
        mul_a = tnow;
        mul_b = recip;
      end else begin
        mul_a = prod_r[63:32];
        mul_b = divisor;
      end
    end else begin
      case (cnt_r[1:0])
        2'd0:    begin mul_a = op_r[31:0];  mul_b = ceat_pkg::MIX_K[31:0];  end
        2'd1:    begin mul_a = op_r[31:0];  mul_b = ceat_pkg::MIX_K[63:32]; end
        default: begin mul_a = op_r[63:32]; mul_b = ceat_pkg::MIX_K[31:0];  end
      endcase
    end
  end

  assign mixv = acc_r ^ (acc_r >> ceat_pkg::MIX_SHIFT);
  assign rest = t_r - prod_r[31:0];
  assign remv = (rest >= divisor) ? (rest - divisor) : rest;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    job_nxt   = job_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    t_nxt     = t_r;
    sset_nxt  = sset_r;
    eset_nxt  = eset_r;
    unique case (state_r)
      ceat_pkg::F_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = '{func: in_ch.func, source_pc: in_ch.source_pc,
                        sink_pc: in_ch.sink_pc};
          op_nxt    = in_ch.sink_pc;
          job_nxt   = 2'd0;
          cnt_nxt   = '0;
          state_nxt = ceat_pkg::F_MUL;
        end
      end
      ceat_pkg::F_MUL: begin
        // low 64 bits of op * k from three 32x32 partial products
        prod_nxt = 64'(mul_a) * 64'(mul_b);
        cnt_nxt  = cnt_r + 6'd1;
        case (cnt_r[1:0])
          2'd0:    ;
          2'd1:    acc_nxt = prod_r;
          default: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = ceat_pkg::F_MIX;
        end
      end
      ceat_pkg::F_MIX: begin
        cnt_nxt = '0;
        if (job_r == 2'd0) begin
          op_nxt    = item_r.source_pc ^ mixv;
          job_nxt   = 2'd1;
          state_nxt = ceat_pkg::F_MUL;
        end else begin
          div_nxt   = mixv;
          rem_nxt   = '0;
          state_nxt = ceat_pkg::F_MOD;
        end
      end
      ceat_pkg::F_MOD: begin
        // remainder by the set count, one 16-bit digit at a time in three steps:
        // reciprocal estimate, back-multiply, then one correcting subtract
        cnt_nxt = cnt_r + 6'd1;
        case (cnt_r[1:0])
          2'd0: begin
            t_nxt    = tnow;
            prod_nxt = 64'(mul_a) * 64'(mul_b);
          end
          2'd1: prod_nxt = 64'(mul_a) * 64'(mul_b);
          default: begin
            rem_nxt = remv[15:0];
            div_nxt = {div_r[47:0], 16'd0};
            cnt_nxt = {cnt_r[5:2] + 4'd1, 2'b00};
            if (cnt_r[3:2] == 2'd3) begin
              cnt_nxt = '0;
              if (job_r == 2'd1) begin
                eset_nxt  = remv[EIW-1:0];
                op_nxt    = item_r.source_pc;
                job_nxt   = 2'd2;
                state_nxt = ceat_pkg::F_MUL;
              end else begin
                sset_nxt  = remv[SIW-1:0];
                state_nxt = ceat_pkg::F_PUSH;
              end
            end
          end
        endcase
      end
      ceat_pkg::F_PUSH: begin
        if (push_ready) begin
          state_nxt = ceat_pkg::F_IDLE;
        end
      end
      default: state_nxt = ceat_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ceat_pkg::F_IDLE);
    push_valid  = (state_r == ceat_pkg::F_PUSH);
    push_item   = item_r;
    push_sset   = sset_r;
    push_eset   = eset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ceat_pkg::F_IDLE;
      job_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      cnt_r   <= cnt_nxt;
    end
    item_r <= item_nxt;
    op_r   <= op_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    t_r    <= t_nxt;
    sset_r <= sset_nxt;
    eset_r <= eset_nxt;
  end

endmodule

`default_nettype wire

FILE: design/ceat_queue.sv
// ----------------------------------------------------------------------------
// ceat_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ceat_queue #(
  parameter int unsigned SIW = 8,
  parameter int unsigned EIW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire ceat_pkg::item_t push_item,
  input  wire logic [SIW-1:0]  push_sset,
  input  wire logic [EIW-1:0]  push_eset,
  output logic                 head_valid,
  input  wire logic            pop,
  output ceat_pkg::item_t      head_item,
  output logic [SIW-1:0]       head_sset,
  output logic [EIW-1:0]       head_eset
);

  localparam int unsigned EW = $bits(ceat_pkg::item_t) + SIW + EIW;

  logic [EW-1:0] slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;
  assign {head_item, head_sset, head_eset} = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      slot_r[wp_r] <= {push_item, push_sset, push_eset};
    end
  end

endmodule

`default_nettype wire

FILE: design/ceat_back.sv
// ----------------------------------------------------------------------------
// ceat_back
// Looks up and updates the source and edge stores, and issues verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ceat_back #(
  parameter int unsigned EDGE_SETS   = 256,
  parameter int unsigned EDGE_WAYS   = 4,
  parameter int unsigned SOURCE_SETS = 256,
  parameter int unsigned SOURCE_WAYS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  output logic                 pop,
  input  wire ceat_pkg::item_t head_item,
  input  wire logic [((SOURCE_SETS > 1) ? $clog2(SOURCE_SETS) : 1)-1:0] head_sset,
  input  wire logic [((EDGE_SETS > 1) ? $clog2(EDGE_SETS) : 1)-1:0]     head_eset,
  ceat_out_if.source           out_ch
);

  localparam int unsigned SIW  = (SOURCE_SETS > 1) ? $clog2(SOURCE_SETS) : 1;
  localparam int unsigned EIW  = (EDGE_SETS > 1) ? $clog2(EDGE_SETS) : 1;
  localparam int unsigned SEW  = 65;
  localparam int unsigned EEW  = 129;
  localparam int unsigned SRW  = SOURCE_WAYS * SEW;
  localparam int unsigned ERW  = EDGE_WAYS * EEW;
  localparam int unsigned CLRN = (EDGE_SETS > SOURCE_SETS) ? EDGE_SETS : SOURCE_SETS;
  localparam int unsigned CW   = $clog2(CLRN) + 1;

  ceat_pkg::back_state_t state_r, state_nxt;
  ceat_pkg::item_t       item_r;
  logic [SIW-1:0]        sset_r;
  logic [EIW-1:0]        eset_r;
  logic [CW-1:0]         clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            verdict_r, verdict_nxt;
  logic                  was_write_r, was_write_nxt;

  logic [SRW-1:0] s_rdata, s_wdata, s_row;
  logic [ERW-1:0] e_rdata, e_wdata, e_row;
  logic [SIW-1:0] s_raddr, s_waddr;
  logic [EIW-1:0] e_raddr, e_waddr;
  logic           s_we, e_we;

  logic           src_hit, edge_hit, s_free, e_free, adv, ins_s, ins_e;
  ceat_pkg::verdict_t verd;

  ceat_ram #(.W(SRW), .D(SOURCE_SETS)) u_src_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  ceat_ram #(.W(ERW), .D(EDGE_SETS)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // way compare and lowest free way, then the new rows
  always_comb begin
    src_hit  = 1'b0;
    edge_hit = 1'b0;
    s_free   = 1'b0;
    e_free   = 1'b0;
    s_row    = s_rdata;
    e_row    = e_rdata;
    for (int w = 0; w < SOURCE_WAYS; w++) begin
      if (s_rdata[w*SEW+64] && s_rdata[w*SEW +: 64] == item_r.source_pc) begin
        src_hit = 1'b1;
      end
      if (!s_rdata[w*SEW+64] && !s_free) begin
        s_free = 1'b1;
        s_row[w*SEW +: SEW] = {1'b1, item_r.source_pc};
      end
    end
    for (int w = 0; w < EDGE_WAYS; w++) begin
      if (e_rdata[w*EEW+128] && e_rdata[w*EEW +: 128] ==
          {item_r.source_pc, item_r.sink_pc}) begin
        edge_hit = 1'b1;
      end
      if (!e_rdata[w*EEW+128] && !e_free) begin
        e_free = 1'b1;
        e_row[w*EEW +: EEW] = {1'b1, item_r.source_pc, item_r.sink_pc};
      end
    end
  end

  always_comb begin
    ins_s = 1'b0;
    ins_e = 1'b0;
    if (!src_hit) begin
      if (s_free && e_free) begin
        verd  = ceat_pkg::V_NEW_SOURCE;
        ins_s = 1'b1;
        ins_e = 1'b1;
      end else begin
        verd = ceat_pkg::V_FULL;
      end
    end else if (!edge_hit) begin
      if (e_free) begin
        verd  = ceat_pkg::V_NEW_EDGE;
        ins_e = 1'b1;
      end else begin
        verd = ceat_pkg::V_FULL;
      end
    end else begin
      verd = ceat_pkg::V_KNOWN;
    end
    if (item_r.func == ceat_pkg::FUNC_PRELOAD && verd != ceat_pkg::V_FULL) begin
      verd = ceat_pkg::V_KNOWN;
    end
  end

  assign adv = (state_r == ceat_pkg::B_READ) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ceat_pkg::B_CLEAR: begin
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CLRN - 1)) begin
          state_nxt = ceat_pkg::B_IDLE;
        end
      end
      ceat_pkg::B_IDLE: begin
        if (head_valid) begin
          state_nxt = ceat_pkg::B_READ;
        end
      end
      ceat_pkg::B_READ: begin
        if (adv) begin
          state_nxt = ceat_pkg::B_IDLE;
        end
      end
      default: state_nxt = ceat_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop           = (state_r == ceat_pkg::B_IDLE) && head_valid;
    s_raddr       = (state_r == ceat_pkg::B_IDLE) ? head_sset : sset_r;
    e_raddr       = (state_r == ceat_pkg::B_IDLE) ? head_eset : eset_r;
    s_waddr       = sset_r;
    e_waddr       = eset_r;
    s_wdata       = s_row;
    e_wdata       = e_row;
    s_we          = adv && ins_s;
    e_we          = adv && ins_e;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    verdict_nxt   = verdict_r;
    was_write_nxt = was_write_r;
    if (state_r == ceat_pkg::B_CLEAR) begin
      s_waddr = clr_r[SIW-1:0];
      e_waddr = clr_r[EIW-1:0];
      s_wdata = '0;
      e_wdata = '0;
      s_we    = (clr_r < CW'(SOURCE_SETS));
      e_we    = (clr_r < CW'(EDGE_SETS));
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      verdict_nxt   = verd;
      was_write_nxt = item_r.func[1];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.verdict   = verdict_r;
  assign out_ch.was_write = was_write_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ceat_pkg::B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    verdict_r   <= verdict_nxt;
    was_write_r <= was_write_nxt;
    if (pop) begin
      item_r <= head_item;
      sset_r <= head_sset;
      eset_r <= head_eset;
    end
  end

  // a full verdict stores nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && verd == ceat_pkg::V_FULL) |-> (!s_we && !e_we))
    else $error("store written on a full verdict");

  // a new source always brings its edge along
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ceat_pkg::B_CLEAR && s_we) |-> e_we)
    else $error("source inserted without its edge");

  // results only come out of a lookup
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ceat_pkg::B_READ))
    else $error("verdict without lookup");

  // no item leaves the queue during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ceat_pkg::B_CLEAR) |-> !pop)
    else $error("pop during clearing pass");

endmodule

`default_nettype wire
